[src/multi_channel_tustin_pid_macros.svh]
// assertion macros shared by the checker
`ifndef MULTI_CHANNEL_TUSTIN_PID_MACROS_SVH
`define MULTI_CHANNEL_TUSTIN_PID_MACROS_SVH

// same-cycle implication, off during reset
`define MCTPID_ASSERT_NOW(label, ant, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define MCTPID_ASSERT_NEXT(label, ant, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |=> (cons)) \
        else $error(msg);

// next-cycle implication, also checked across reset
`define MCTPID_ASSERT_NEXT_ALWAYS(label, ant, cons, msg) \
    label: assert property (@(posedge aclk) (ant) |=> (cons)) \
        else $error(msg);

`endif

[src/mctpid_pkg.sv]
// types, codes and constants of the multi-channel tustin pid
package mctpid_pkg;

    localparam int CHANNELS_DEF  = 3;
    localparam int FRAC_BITS_DEF = 16;
    localparam int CH_FIELD_W    = 4;
    localparam int DATA_W        = 32;
    localparam int LIMIT_W       = 31;
    localparam int CFG_IDX_W     = 3;
    localparam int S_TDATA_W     = 40;
    localparam int PROD_W        = 2 * DATA_W;
    localparam int SUM_W         = PROD_W + 3;

    localparam logic signed [DATA_W-1:0] COEF_ERR0_RST = 32'sd3188270;
    localparam logic signed [DATA_W-1:0] COEF_ERR1_RST = -32'sd6304150;
    localparam logic signed [DATA_W-1:0] COEF_ERR2_RST = 32'sd3116300;
    localparam logic signed [DATA_W-1:0] COEF_OUT1_RST = 32'sd103737;
    localparam logic signed [DATA_W-1:0] COEF_OUT2_RST = -32'sd38201;
    localparam logic [LIMIT_W-1:0]       ERR_LIMIT_RST = 31'd11438;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_BAD_CH = 2'd1,
        STATUS_FAULT  = 2'd2
    } status_t;

    typedef enum logic {
        MODE_STEP  = 1'b0,
        MODE_CLEAR = 1'b1
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_ERR0 = 3'd0,
        CFG_COEF_ERR1 = 3'd1,
        CFG_COEF_ERR2 = 3'd2,
        CFG_COEF_OUT1 = 3'd3,
        CFG_COEF_OUT2 = 3'd4,
        CFG_ERR_LIMIT = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] coef_err0;
        logic signed [DATA_W-1:0] coef_err1;
        logic signed [DATA_W-1:0] coef_err2;
        logic signed [DATA_W-1:0] coef_out1;
        logic signed [DATA_W-1:0] coef_out2;
        logic [LIMIT_W-1:0]       error_limit;
    } coef_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] err1;
        logic signed [DATA_W-1:0] err2;
        logic signed [DATA_W-1:0] out1;
        logic signed [DATA_W-1:0] out2;
    } hist_t;

    typedef struct packed {
        logic                     en;
        logic                     clr;
        logic [CH_FIELD_W-1:0]    channel;
        logic signed [DATA_W-1:0] err;
        logic signed [DATA_W-1:0] out;
    } hist_wr_t;

    typedef struct packed {
        mode_t                    mode;
        logic [CH_FIELD_W-1:0]    channel;
        logic signed [DATA_W-1:0] error_in;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] drive;
        status_t                  status;
    } result_t;

endpackage

[src/mctpid_cfg.sv]
// coefficient and limit registers with their write port
module mctpid_cfg
    import mctpid_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    output coef_t                coef
);

    coef_t coef_reg;
    coef_t coef_next;

    always_comb begin
        coef_next = coef_reg;
        if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_COEF_ERR0: coef_next.coef_err0 = $signed(cfg_data);
                CFG_COEF_ERR1: coef_next.coef_err1 = $signed(cfg_data);
                CFG_COEF_ERR2: coef_next.coef_err2 = $signed(cfg_data);
                CFG_COEF_OUT1: coef_next.coef_out1 = $signed(cfg_data);
                CFG_COEF_OUT2: coef_next.coef_out2 = $signed(cfg_data);
                CFG_ERR_LIMIT: coef_next.error_limit = cfg_data[LIMIT_W-1:0];
                default: coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg.coef_err0   <= COEF_ERR0_RST;
            coef_reg.coef_err1   <= COEF_ERR1_RST;
            coef_reg.coef_err2   <= COEF_ERR2_RST;
            coef_reg.coef_out1   <= COEF_OUT1_RST;
            coef_reg.coef_out2   <= COEF_OUT2_RST;
            coef_reg.error_limit <= ERR_LIMIT_RST;
        end else begin
            coef_reg <= coef_next;
        end
    end

    assign coef = coef_reg;

endmodule

[src/mctpid_hist.sv]
// per-channel history of the last two errors and outputs
module mctpid_hist
    import mctpid_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [CH_FIELD_W-1:0] rd_channel,
    output hist_t                 hist_rd,
    input  hist_wr_t              hist_wr
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic signed [DATA_W-1:0] err1_reg [CHANNELS];
    logic signed [DATA_W-1:0] err2_reg [CHANNELS];
    logic signed [DATA_W-1:0] out1_reg [CHANNELS];
    logic signed [DATA_W-1:0] out2_reg [CHANNELS];

    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] wr_idx;
    logic             rd_ok;

    assign rd_idx = rd_channel[IDX_W-1:0];
    assign wr_idx = hist_wr.channel[IDX_W-1:0];
    assign rd_ok  = ({1'b0, rd_channel} < (CH_FIELD_W + 1)'(CHANNELS));

    always_comb begin
        hist_rd = '0;
        if (rd_ok) begin
            hist_rd.err1 = err1_reg[rd_idx];
            hist_rd.err2 = err2_reg[rd_idx];
            hist_rd.out1 = out1_reg[rd_idx];
            hist_rd.out2 = out2_reg[rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                err1_reg[i] <= '0;
                err2_reg[i] <= '0;
                out1_reg[i] <= '0;
                out2_reg[i] <= '0;
            end
        end else if (hist_wr.en) begin
            if (hist_wr.clr) begin
                err1_reg[wr_idx] <= '0;
                err2_reg[wr_idx] <= '0;
                out1_reg[wr_idx] <= '0;
                out2_reg[wr_idx] <= '0;
            end else begin
                err2_reg[wr_idx] <= err1_reg[wr_idx];
                err1_reg[wr_idx] <= hist_wr.err;
                out2_reg[wr_idx] <= out1_reg[wr_idx];
                out1_reg[wr_idx] <= hist_wr.out;
            end
        end
    end

endmodule

[src/mctpid_calc.sv]
// control step arithmetic: five products, rounding, saturation and checks
module mctpid_calc
    import mctpid_pkg::*;
#(
    parameter int CHANNELS  = CHANNELS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic     fire,
    input  item_t    item,
    input  coef_t    coef,
    input  hist_t    hist_rd,
    output result_t  result,
    output hist_wr_t hist_wr
);

    localparam logic signed [SUM_W-1:0] RND_OFS = SUM_W'(1) <<< (FRAC_BITS - 1);

    logic                     ch_ok;
    logic [DATA_W:0]          mag;
    logic                     over;
    logic signed [PROD_W-1:0] p_e0;
    logic signed [PROD_W-1:0] p_e1;
    logic signed [PROD_W-1:0] p_e2;
    logic signed [PROD_W-1:0] p_u1;
    logic signed [PROD_W-1:0] p_u2;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  scaled;
    logic [SUM_W-DATA_W:0]    top_bits;
    logic signed [DATA_W-1:0] sat;

    assign ch_ok = ({1'b0, item.channel} < (CH_FIELD_W + 1)'(CHANNELS));
    assign mag   = item.error_in[DATA_W-1] ? ((DATA_W + 1)'(0) - {1'b1, item.error_in})
                                           : {1'b0, item.error_in};
    assign over  = (mag > {2'b00, coef.error_limit});

    assign p_e0 = $signed(coef.coef_err0) * $signed(item.error_in);
    assign p_e1 = $signed(coef.coef_err1) * $signed(hist_rd.err1);
    assign p_e2 = $signed(coef.coef_err2) * $signed(hist_rd.err2);
    assign p_u1 = $signed(coef.coef_out1) * $signed(hist_rd.out1);
    assign p_u2 = $signed(coef.coef_out2) * $signed(hist_rd.out2);

    assign sum = SUM_W'(p_e0) + SUM_W'(p_e1) + SUM_W'(p_e2) + SUM_W'(p_u1) + SUM_W'(p_u2);
    assign scaled   = (sum + RND_OFS) >>> FRAC_BITS;
    assign top_bits = scaled[SUM_W-1:DATA_W-1];

    always_comb begin
        priority if ((&top_bits) || !(|top_bits)) begin
            sat = scaled[DATA_W-1:0];
        end else if (scaled[SUM_W-1]) begin
            sat = {1'b1, {(DATA_W - 1){1'b0}}};
        end else begin
            sat = {1'b0, {(DATA_W - 1){1'b1}}};
        end
    end

    always_comb begin
        result          = '0;
        result.status   = STATUS_OK;
        hist_wr.en      = 1'b0;
        hist_wr.clr     = (item.mode == MODE_CLEAR);
        hist_wr.channel = item.channel;
        hist_wr.err     = item.error_in;
        hist_wr.out     = sat;
        priority if (!ch_ok) begin
            result.status = STATUS_BAD_CH;
        end else if (item.mode == MODE_CLEAR) begin
            hist_wr.en = fire;
        end else if (over) begin
            result.status = STATUS_FAULT;
        end else begin
            result.drive = sat;
            hist_wr.en   = fire;
        end
    end

endmodule

[src/multi_channel_tustin_pid.sv]
// words pass through the input register, then the result register; one per
// cycle unless m_tready stalls. The history read, five multipliers and
// the rounding adder sit in one stage between the input and result registers
// a word for a channel follows the previous one on that channel back to back
// reset: synchronous, active low; clears history, both stage valids and
// loads the default coefficients and limit
module multi_channel_tustin_pid
    import mctpid_pkg::*;
#(
    parameter int CHANNELS  = CHANNELS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // channel, error_in, zero pad
    input  logic                 s_tuser,   // mode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [DATA_W-1:0]    m_tdata,   // drive
    output logic [1:0]           m_tuser,   // status
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    coef_t    coef;
    hist_t    hist_rd;
    hist_wr_t hist_wr;
    result_t  calc_result;
    item_t    s_item;

    logic    in_valid_reg;
    logic    in_valid_next;
    item_t   item_reg;
    item_t   item_next;
    logic    m_valid_reg;
    logic    m_valid_next;
    result_t result_reg;
    result_t result_next;

    logic s_accept;
    logic advance;
    logic fire;

    assign s_item.mode     = mode_t'(s_tuser);
    assign s_item.channel  = s_tdata[CH_FIELD_W-1:0];
    assign s_item.error_in = $signed(s_tdata[CH_FIELD_W+DATA_W-1:CH_FIELD_W]);

    assign advance  = !m_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign cfg_ready = 1'b1;

    mctpid_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef)
    );

    mctpid_hist #(
        .CHANNELS (CHANNELS)
    ) u_hist (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rd_channel (item_reg.channel),
        .hist_rd    (hist_rd),
        .hist_wr    (hist_wr)
    );

    mctpid_calc #(
        .CHANNELS  (CHANNELS),
        .FRAC_BITS (FRAC_BITS)
    ) u_calc (
        .fire    (fire),
        .item    (item_reg),
        .coef    (coef),
        .hist_rd (hist_rd),
        .result  (calc_result),
        .hist_wr (hist_wr)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        item_next     = item_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
            item_next     = s_item;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        result_next  = result_reg;
        if (fire) begin
            m_valid_next = 1'b1;
            result_next  = calc_result;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        result_reg <= result_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = result_reg.drive;
    assign m_tuser  = result_reg.status;

endmodule

[src/mctpid_chk.sv]
// port checker for the multi-channel tustin pid and its bind
`include "multi_channel_tustin_pid_macros.svh"

module mctpid_chk
    import mctpid_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata,
    input logic [1:0]        m_tuser
);

    `MCTPID_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")
    `MCTPID_ASSERT_NOW(a_err_zero, m_tvalid && (m_tuser != STATUS_OK), m_tdata == '0, "error result carries nonzero drive")
    `MCTPID_ASSERT_NOW(a_ready_stall, !s_tready, m_tvalid && !m_tready, "input stalled without output back-pressure")
    `MCTPID_ASSERT_NEXT_ALWAYS(a_reset_empty, !aresetn, !m_tvalid, "result valid right after reset")

endmodule

bind multi_channel_tustin_pid mctpid_chk u_chk (.*);
